/* src/oewm_pkg.sv */
// Shared types and constants of the one-edit word matcher.
package oewm_pkg;

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 16;

    // Word counter wraps to zero on reaching this depth as well as at 2^INDEX_W.
    localparam int unsigned DICT_DEPTH = 65536;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_DICT  = 1'b1;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_EQUAL   = 3'd1,
        KIND_SUBST   = 3'd2,
        KIND_EXTRA   = 3'd3,
        KIND_MISSING = 3'd4
    } t_kind;

    typedef struct packed {
        logic              opcode;
        logic [CHAR_W-1:0] char_code;
        logic              end_of_word;
    } t_item;

    typedef struct packed {
        logic [2:0]         match_kind;
        logic [INDEX_W-1:0] word_index;
    } t_result;

endpackage

/* src/oewm_queue.sv */
// Small first-in first-out queue of fixed-width words.
module oewm_queue
    import oewm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [COUNT_W-1:0] r_count;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == COUNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + COUNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(DEPTH))
        else $error("queue fill level beyond depth");

endmodule

/* src/oewm_front.sv */
// Front end: accepts characters, keeps query and current word, issues finished words.
module oewm_front
    import oewm_pkg::*;
#(
    parameter int MAX_LEN = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  t_item                          i_item,
    output logic                           o_full,
    input  logic                           i_job_full,
    input  logic                           i_job_empty,
    output logic                           o_job_push,
    output logic [MAX_LEN-1:0][CHAR_W-1:0] o_job_chars,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_job_len,
    output logic                           o_job_long,
    output logic [INDEX_W-1:0]             o_job_index,
    output logic [MAX_LEN-1:0][CHAR_W-1:0] o_query_chars,
    output logic [$clog2(MAX_LEN+1)-1:0]   o_query_len,
    output logic                           o_query_long
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);

    logic [MAX_LEN-1:0][CHAR_W-1:0] r_qchars;
    logic [LEN_W-1:0]               r_qlen;
    logic                           r_qlong;
    logic                           r_qdone;
    logic [MAX_LEN-1:0][CHAR_W-1:0] r_echars;
    logic [LEN_W-1:0]               r_elen;
    logic                           r_elong;
    logic [INDEX_W-1:0]             r_cnt;

    logic [MAX_LEN-1:0][CHAR_W-1:0] n_echars;
    logic [INDEX_W-1:0]             n_cnt;
    logic [INDEX_W:0]               cnt_inc;
    logic                           accept;
    logic                           new_query;
    logic                           query_take;
    logic                           dict_take;
    logic [LEN_W-1:0]               q_base;
    logic                           q_room;
    logic                           e_room;

    // A new query overwrites the query store, so hold it until queued words are classified.
    assign new_query  = (i_item.opcode == OP_QUERY) && r_qdone;
    assign o_full     = i_job_full || (new_query && !i_job_empty);
    assign accept     = i_push && !o_full;
    assign query_take = accept && (i_item.opcode == OP_QUERY);
    assign dict_take  = accept && (i_item.opcode == OP_DICT) && r_qdone;

    assign q_base = new_query ? '0 : r_qlen;
    assign q_room = q_base < LEN_W'(MAX_LEN);
    assign e_room = r_elen < LEN_W'(MAX_LEN);

    always_comb begin
        n_echars = r_echars;
        if (e_room) begin
            n_echars[r_elen[IDX_W-1:0]] = i_item.char_code;
        end
    end

    assign cnt_inc = {1'b0, r_cnt} + (INDEX_W + 1)'(1);
    assign n_cnt   = (32'(cnt_inc[INDEX_W-1:0]) >= DICT_DEPTH) ? '0 : cnt_inc[INDEX_W-1:0];

    assign o_job_push    = dict_take && i_item.end_of_word;
    assign o_job_chars   = n_echars;
    assign o_job_len     = e_room ? r_elen + LEN_W'(1) : r_elen;
    assign o_job_long    = r_elong || !e_room;
    assign o_job_index   = r_cnt;
    assign o_query_chars = r_qchars;
    assign o_query_len   = r_qlen;
    assign o_query_long  = r_qlong;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen  <= '0;
            r_qlong <= 1'b0;
            r_qdone <= 1'b0;
            r_elen  <= '0;
            r_elong <= 1'b0;
            r_cnt   <= '0;
        end else if (query_take) begin
            r_qlen  <= q_room ? q_base + LEN_W'(1) : q_base;
            r_qlong <= (r_qlong && !new_query) || !q_room;
            r_qdone <= i_item.end_of_word;
            if (new_query) begin
                // drop any partial word and restart the numbering
                r_cnt   <= '0;
                r_elen  <= '0;
                r_elong <= 1'b0;
            end
        end else if (dict_take) begin
            if (i_item.end_of_word) begin
                r_elen  <= '0;
                r_elong <= 1'b0;
                r_cnt   <= n_cnt;
            end else if (e_room) begin
                r_elen <= r_elen + LEN_W'(1);
            end else begin
                r_elong <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_take && q_room) begin
            r_qchars[q_base[IDX_W-1:0]] <= i_item.char_code;
        end
        if (dict_take && !i_item.end_of_word) begin
            r_echars <= n_echars;
        end
    end

    a_job_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> !i_job_full)
        else $error("finished word issued into a full job queue");

    a_query_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && new_query) |-> i_job_empty)
        else $error("query replaced while words still await classification");

    a_query_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && new_query) |=> (r_cnt == '0 && r_qlen == LEN_W'(1) && r_elen == '0))
        else $error("new query did not restart query, word and counter");

endmodule

/* src/oewm_back.sv */
// Back end: classifies one finished word against the query.
module oewm_back
    import oewm_pkg::*;
#(
    parameter int MAX_LEN = 20
) (
    input  logic                           i_job_valid,
    input  logic [MAX_LEN-1:0][CHAR_W-1:0] i_job_chars,
    input  logic [$clog2(MAX_LEN+1)-1:0]   i_job_len,
    input  logic                           i_job_long,
    input  logic [INDEX_W-1:0]             i_job_index,
    input  logic [MAX_LEN-1:0][CHAR_W-1:0] i_query_chars,
    input  logic [$clog2(MAX_LEN+1)-1:0]   i_query_len,
    input  logic                           i_query_long,
    input  logic                           i_out_full,
    output logic                           o_job_take,
    output t_result                        o_result
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [MAX_LEN-1:0] m_eq;
    logic [MAX_LEN-1:0] in_q;
    logic [MAX_LEN-1:0] in_w;
    logic [MAX_LEN-1:0] pre_eq;
    logic [MAX_LEN-1:0] sh_ext;
    logic [MAX_LEN-1:0] sh_mis;
    logic [MAX_LEN-1:0] ok_ext;
    logic [MAX_LEN-1:0] ok_mis;
    logic [MAX_LEN-1:0] neq;
    logic [LEN_W:0]     q_plus;
    logic [LEN_W:0]     w_plus;
    t_kind              kind;

    assign o_job_take = i_job_valid && !i_out_full;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_pos
        localparam logic [MAX_LEN-1:0] LOW = {MAX_LEN{1'b1}} >> (MAX_LEN - 1 - j);

        assign m_eq[j]   = (i_query_chars[j] == i_job_chars[j]);
        assign in_q[j]   = LEN_W'(j) < i_query_len;
        assign in_w[j]   = LEN_W'(j) < i_job_len;
        // all positions up to and including this one agree
        assign pre_eq[j] = &(m_eq | ~LOW);
        if (j + 1 < MAX_LEN) begin : g_shift
            assign sh_ext[j] = (i_job_chars[j+1] == i_query_chars[j]);
            assign sh_mis[j] = (i_query_chars[j+1] == i_job_chars[j]);
        end else begin : g_last
            assign sh_ext[j] = 1'b0;
            assign sh_mis[j] = 1'b0;
        end
        // past the first mismatch, the longer word must agree one place on
        assign ok_ext[j] = !in_q[j] || pre_eq[j] || sh_ext[j];
        assign ok_mis[j] = !in_w[j] || pre_eq[j] || sh_mis[j];
        assign neq[j]    = in_q[j] && !m_eq[j];
    end

    assign q_plus = {1'b0, i_query_len} + (LEN_W + 1)'(1);
    assign w_plus = {1'b0, i_job_len} + (LEN_W + 1)'(1);

    always_comb begin
        kind = KIND_NONE;
        priority if (i_query_long || i_job_long) begin
            kind = KIND_NONE;
        end else if (i_query_len == i_job_len) begin
            if (neq == '0) begin
                kind = KIND_EQUAL;
            end else if ((neq & (neq - MAX_LEN'(1))) == '0) begin
                kind = KIND_SUBST;
            end
        end else if ({1'b0, i_job_len} == q_plus) begin
            if (&ok_ext) begin
                kind = KIND_EXTRA;
            end
        end else if ({1'b0, i_query_len} == w_plus) begin
            if (&ok_mis) begin
                kind = KIND_MISSING;
            end
        end else begin
            // lengths two or more apart
            kind = KIND_NONE;
        end
    end

    assign o_result.match_kind = kind;
    assign o_result.word_index = i_job_index;

endmodule

/* src/one_edit_word_matcher_top.sv */
// Top level of the one-edit word matcher.
//
// Load a query word, then stream dictionary words, one character per transaction; each
// dictionary word gets one result at its last character: the match class (none, equal,
// one substitution, one extra character, one missing character) and its index since the
// query was loaded. Words longer than MAX_LEN characters class as no relation. The block
// takes one character every cycle while full is low. A finished word passes through a
// two-entry job queue to the classifier, and its result lands in a two-entry result queue,
// so the word is registered in the job queue and its result in the result queue before it
// shows on the result port. The first character of a new query is held (full high) while a
// finished word still waits in the job queue, since the classifier reads the stored query.
// Dictionary characters that arrive before the query is complete are dropped.
module one_edit_word_matcher_top
    import oewm_pkg::*;
#(
    parameter int MAX_LEN = 20
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    input  t_item   i_item,
    output logic    full,
    input  logic    pop,
    output t_result o_result,
    output logic    empty
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int JOB_W = MAX_LEN * CHAR_W + LEN_W + 1 + INDEX_W;
    localparam int RES_W = $bits(t_result);

    logic                           job_push;
    logic [MAX_LEN-1:0][CHAR_W-1:0] job_chars;
    logic [LEN_W-1:0]               job_len;
    logic                           job_long;
    logic [INDEX_W-1:0]             job_index;
    logic [MAX_LEN-1:0][CHAR_W-1:0] query_chars;
    logic [LEN_W-1:0]               query_len;
    logic                           query_long;
    logic                           job_full;
    logic                           job_empty;
    logic                           job_take;
    logic [JOB_W-1:0]               job_word;
    logic [MAX_LEN-1:0][CHAR_W-1:0] q_chars;
    logic [LEN_W-1:0]               q_len;
    logic                           q_long;
    logic [INDEX_W-1:0]             q_index;
    logic                           out_full;
    t_result                        back_result;
    logic [RES_W-1:0]               out_word;

    oewm_front #(
        .MAX_LEN(MAX_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_item        (i_item),
        .o_full        (full),
        .i_job_full    (job_full),
        .i_job_empty   (job_empty),
        .o_job_push    (job_push),
        .o_job_chars   (job_chars),
        .o_job_len     (job_len),
        .o_job_long    (job_long),
        .o_job_index   (job_index),
        .o_query_chars (query_chars),
        .o_query_len   (query_len),
        .o_query_long  (query_long)
    );

    oewm_queue #(
        .WIDTH(JOB_W),
        .DEPTH(2)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  ({job_chars, job_len, job_long, job_index}),
        .o_full  (job_full),
        .i_pop   (job_take),
        .o_data  (job_word),
        .o_empty (job_empty)
    );

    assign {q_chars, q_len, q_long, q_index} = job_word;

    oewm_back #(
        .MAX_LEN(MAX_LEN)
    ) u_back (
        .i_job_valid   (!job_empty),
        .i_job_chars   (q_chars),
        .i_job_len     (q_len),
        .i_job_long    (q_long),
        .i_job_index   (q_index),
        .i_query_chars (query_chars),
        .i_query_len   (query_len),
        .i_query_long  (query_long),
        .i_out_full    (out_full),
        .o_job_take    (job_take),
        .o_result      (back_result)
    );

    oewm_queue #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_take),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_word),
        .o_empty (empty)
    );

    assign o_result = t_result'(out_word);

endmodule

/* tb/tb_one_edit_word_matcher_top.sv */
// Self-checking testbench for the one-edit word matcher: directed cases and random edits.
`timescale 1ns / 1ps

module tb_one_edit_word_matcher_top;
    import oewm_pkg::*;

    localparam int MAX_LEN = 20;
    localparam int RANDOM_ITEMS = 1700;

    typedef logic [CHAR_W-1:0] t_word [MAX_LEN];
    typedef logic [CHAR_W-1:0] t_chars [$];

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    t_item   i_item = '0;
    logic    full;
    logic    pop = 1'b0;
    t_result o_result;
    logic    empty;

    one_edit_word_matcher_top #(.MAX_LEN(MAX_LEN)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .pop      (pop),
        .o_result (o_result),
        .empty    (empty)
    );

    always #4 i_clk = ~i_clk;

    // Mirror of the matcher state
    t_word              q_chars = '{default: '0};
    int unsigned        q_len = 0;
    bit                 q_long = 1'b0;
    bit                 q_done = 1'b0;
    t_word              e_chars = '{default: '0};
    int unsigned        e_len = 0;
    bit                 e_long = 1'b0;
    logic [INDEX_W-1:0] word_cnt = '0;

    t_result pending_results [$];
    t_result want;

    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned err_count = 0;
    int          kind_seen [5] = '{default: 0};

    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int hold_req = 0;
    int hold_left = 0;
    int stall_left = 0;

    // True if short word (length n) is long word (length n+1) with one character removed
    function automatic bit drops_one(input t_word lw, input t_word sw, input int unsigned n);
        int unsigned i;
        i = 0;
        while (i < n && lw[i] == sw[i]) i++;
        for (int unsigned j = i; j < n; j++) begin
            if (lw[j+1] != sw[j]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_kind classify_word();
        int diff;
        diff = 0;
        if (q_long || e_long) return KIND_NONE;
        if (e_len == q_len) begin
            for (int unsigned i = 0; i < q_len; i++) begin
                if (q_chars[i] != e_chars[i]) diff++;
            end
            if (diff == 0) return KIND_EQUAL;
            if (diff == 1) return KIND_SUBST;
            return KIND_NONE;
        end
        if (e_len == q_len + 1) return drops_one(e_chars, q_chars, q_len) ? KIND_EXTRA : KIND_NONE;
        if (q_len == e_len + 1) return drops_one(q_chars, e_chars, e_len) ? KIND_MISSING : KIND_NONE;
        return KIND_NONE;
    endfunction

    function automatic void clear_entry();
        e_chars = '{default: '0};
        e_len = 0;
        e_long = 1'b0;
    endfunction

    // Advance the mirror by one accepted transaction
    function automatic void track_item(input t_item it);
        t_result r;
        int unsigned cnt;
        if (it.opcode == OP_QUERY) begin
            if (q_done) begin
                q_chars = '{default: '0};
                q_len = 0;
                q_long = 1'b0;
                q_done = 1'b0;
                word_cnt = '0;
                clear_entry();
            end
            if (q_len < MAX_LEN) begin
                q_chars[q_len] = it.char_code;
                q_len++;
            end else begin
                q_long = 1'b1;
            end
            if (it.end_of_word) q_done = 1'b1;
            return;
        end
        // drop dictionary characters until the query is complete
        if (!q_done) return;
        if (e_len < MAX_LEN) begin
            e_chars[e_len] = it.char_code;
            e_len++;
        end else begin
            e_long = 1'b1;
        end
        if (!it.end_of_word) return;
        r.match_kind = 3'(classify_word());
        r.word_index = word_cnt;
        pending_results.push_back(r);
        cnt = (32'(word_cnt) + 1) & 32'hFFFF;
        if (cnt >= DICT_DEPTH) cnt = 0;
        word_cnt = INDEX_W'(cnt);
        clear_entry();
    endfunction

    function automatic int gap_len();
        int r;
        if (!send_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char(input bit narrow);
        if (narrow) return CHAR_W'($urandom_range(1, 3));
        return CHAR_W'($urandom_range(1, 255));
    endfunction

    // Called at a falling edge; returns at a falling edge after the transaction
    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch, input logic eow,
                             input int gap);
        t_item it;
        it.opcode = op;
        it.char_code = ch;
        it.end_of_word = eow;
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        track_item(it);
        items_sent++;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic release_push();
        push <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_word(input logic op, input t_chars w, input bit closed);
        for (int i = 0; i < w.size(); i++) begin
            send_item(op, w[i], closed && (i == w.size() - 1), gap_len());
        end
    endtask

    task automatic test_before_query();
        // dictionary traffic before any query must be ignored
        send_item(OP_DICT, 8'h01, 1'b1, gap_len());
        send_item(OP_DICT, 8'hFF, 1'b0, gap_len());
        send_item(OP_DICT, 8'h80, 1'b1, gap_len());
        release_push();
    endtask

    task automatic test_directed();
        send_word(OP_QUERY, '{8'h01, 8'hFF, 8'h80}, 1'b1);
        send_word(OP_DICT, '{8'h01, 8'hFF, 8'h80}, 1'b1);
        send_word(OP_DICT, '{8'h01, 8'h7F, 8'h80}, 1'b1);
        send_word(OP_DICT, '{8'hFE, 8'h7F, 8'h80}, 1'b1);
        send_word(OP_DICT, '{8'h55, 8'h01, 8'hFF, 8'h80}, 1'b1);
        send_word(OP_DICT, '{8'h01, 8'hFF, 8'h80, 8'h01}, 1'b1);
        send_word(OP_DICT, '{8'h01, 8'h80}, 1'b1);
        send_word(OP_DICT, '{8'h01, 8'hFF}, 1'b1);
        send_word(OP_DICT, '{8'h01}, 1'b1);
        // half a word, then a new query discards it and restarts the index
        send_word(OP_DICT, '{8'h01, 8'hFF}, 1'b0);
        send_item(OP_QUERY, 8'h7F, 1'b0, gap_len());
        send_item(OP_DICT, 8'h7F, 1'b1, gap_len());
        send_item(OP_QUERY, 8'h01, 1'b1, gap_len());
        send_word(OP_DICT, '{8'h01}, 1'b1);
        send_word(OP_DICT, '{8'h7F}, 1'b1);
        release_push();
    endtask

    task automatic test_overlong();
        t_chars w;
        w = {};
        for (int i = 0; i < MAX_LEN; i++) w.push_back(rand_char(1'b0));
        send_word(OP_QUERY, w, 1'b1);
        send_word(OP_DICT, w, 1'b1);
        w.push_back(8'hFF);
        send_word(OP_DICT, w, 1'b1);
        // query one past the limit matches nothing
        send_word(OP_QUERY, w, 1'b1);
        void'(w.pop_back());
        send_word(OP_DICT, w, 1'b1);
        send_word(OP_DICT, '{8'h01}, 1'b1);
        release_push();
    endtask

    task automatic test_backpressure();
        bit saved;
        saved = send_idle_on;
        send_idle_on = 1'b0;
        send_word(OP_QUERY, '{8'h41}, 1'b1);
        hold_req = 300;
        for (int i = 0; i < 40; i++) send_word(OP_DICT, '{rand_char(1'b1) + 8'h40}, 1'b1);
        send_idle_on = saved;
        release_push();
    endtask

    task automatic test_random();
        t_chars q, w;
        int useful, qlen, nwords, op, pos, cut;
        logic [CHAR_W-1:0] c;
        bit narrow;
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            // some groups run with no idling on either side
            send_idle_on = ($urandom_range(0, 4) != 0);
            recv_idle_on = ($urandom_range(0, 4) != 0);
            narrow = ($urandom_range(0, 2) == 0);
            qlen = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 6) : $urandom_range(15, 22);
            q = {};
            for (int i = 0; i < qlen; i++) q.push_back(rand_char(narrow));
            for (int i = 0; i < qlen; i++) begin
                send_item(OP_QUERY, q[i], i == qlen - 1, gap_len());
                useful++;
                // stray dictionary character inside the query
                if (i != qlen - 1 && $urandom_range(0, 19) == 0)
                    send_item(OP_DICT, rand_char(1'b0), 1'($urandom_range(0, 1)), gap_len());
            end
            nwords = $urandom_range(1, 8);
            for (int n = 0; n < nwords; n++) begin
                op = $urandom_range(0, 9);
                w = {};
                if (op <= 1) begin
                    w = q;
                end else if (op <= 3) begin
                    w = q;
                    pos = $urandom_range(0, qlen - 1);
                    do c = rand_char(narrow); while (c == q[pos]);
                    w[pos] = c;
                end else if (op <= 5) begin
                    pos = $urandom_range(0, qlen);
                    for (int i = 0; i <= qlen; i++) begin
                        if (i == pos) w.push_back(rand_char(narrow));
                        if (i < qlen) w.push_back(q[i]);
                    end
                end else if (op <= 7 && qlen > 1) begin
                    pos = $urandom_range(0, qlen - 1);
                    for (int i = 0; i < qlen; i++) if (i != pos) w.push_back(q[i]);
                end else if (op == 8) begin
                    for (int i = 0; i < qlen; i++) w.push_back(rand_char(narrow));
                end else begin
                    cut = $urandom_range(1, 7);
                    for (int i = 0; i < cut; i++) w.push_back(rand_char(narrow));
                end
                if (w.size() == 0) w.push_back(rand_char(narrow));
                if ($urandom_range(0, 24) == 0) begin
                    // abandon this word midway; the next query discards it
                    cut = $urandom_range(1, w.size());
                    while (w.size() > cut) void'(w.pop_back());
                    send_word(OP_DICT, w, 1'b0);
                    useful += w.size();
                    break;
                end
                send_word(OP_DICT, w, 1'b1);
                useful += w.size();
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        release_push();
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (!recv_idle_on) begin
            pop <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if ($urandom_range(0, 99) < 70) begin
            pop <= 1'b1;
        end else begin
            stall_left = ($urandom_range(0, 19) != 0) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 60);
            pop <= 1'b0;
        end
    end

    // Compare each popped result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: match_kind %0d word_index %0d",
                       o_result.match_kind, o_result.word_index);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.match_kind !== want.match_kind) begin
                    $error("match_kind: expected %0d, actual %0d",
                           want.match_kind, o_result.match_kind);
                    err_count++;
                end
                if (o_result.word_index !== want.word_index) begin
                    $error("word_index: expected %0d, actual %0d",
                           want.word_index, o_result.word_index);
                    err_count++;
                end
                if (want.match_kind <= KIND_MISSING) kind_seen[want.match_kind]++;
                results_seen++;
            end
        end
    end

    initial begin
        #24_000_000;
        $display("one_edit_word_matcher_top: mismatch");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_before_query();
        test_directed();
        test_overlong();
        test_backpressure();
        test_random();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) err_count++;

        $display("Sent %0d transactions, checked %0d results (none %0d, equal %0d, subst %0d,",
                 items_sent, results_seen, kind_seen[KIND_NONE], kind_seen[KIND_EQUAL],
                 kind_seen[KIND_SUBST]);
        $display("extra %0d, missing %0d) with overlong words, query restarts and a long hold-off.",
                 kind_seen[KIND_EXTRA], kind_seen[KIND_MISSING]);
        if (err_count == 0) begin
            $display("one_edit_word_matcher_top: match");
        end else begin
            $display("one_edit_word_matcher_top: mismatch");
        end
        $finish;
    end

endmodule
